### hw/rtl/dta_pkg.sv
// Shared types, constants and calendar helpers for the date-time plus duration block.
// Used by dta_front, dta_back and datetime_add_duration; depends on nothing.
`default_nettype none
package dta_pkg;

  localparam int YW    = 20;
  localparam int DAYW  = 24;
  localparam int MAGW  = 34;
  localparam int DIVW  = 26;
  localparam int SW    = 36;
  localparam int QW    = 20;
  localparam int MULW  = 26;
  localparam int RCPW  = 27;
  localparam int PRODW = MULW + RCPW;

  localparam logic [DIVW-1:0] MONTHS_PER_YEAR  = DIVW'(12);
  localparam logic [DIVW-1:0] YEARS_PER_CYCLE  = DIVW'(400);
  localparam logic [DIVW-1:0] MICRO_PER_MINUTE = DIVW'(60000000);
  localparam logic [DIVW-1:0] MINUTES_PER_HOUR = DIVW'(60);
  localparam logic [DIVW-1:0] HOURS_PER_DAY    = DIVW'(24);
  localparam logic [DIVW-1:0] MICRO_PER_SECOND = DIVW'(1000000);
  localparam logic signed [DAYW-1:0] DAYS_PER_CYCLE = DAYW'(146097);

  // Rounded-up reciprocals and their shifts for exact floor division by each constant.
  // The microsecond magnitude is divided by 256 first and then by 234375.
  localparam logic [RCPW-1:0] RCP_MONTH  = RCPW'(1398102);
  localparam logic [RCPW-1:0] RCP_YEAR   = RCPW'(167773);
  localparam logic [RCPW-1:0] RCP_MICRO  = RCPW'(37529997);
  localparam logic [RCPW-1:0] RCP_MINUTE = RCPW'(17895698);
  localparam logic [RCPW-1:0] RCP_HOUR   = RCPW'(22369622);
  localparam logic [RCPW-1:0] RCP_SECOND = RCPW'(70368745);
  localparam logic [5:0]      SH_MONTH   = 6'd24;
  localparam logic [5:0]      SH_YEAR    = 6'd26;
  localparam logic [5:0]      SH_MICRO   = 6'd43;
  localparam logic [5:0]      SH_MINUTE  = 6'd30;
  localparam logic [5:0]      SH_HOUR    = 6'd29;
  localparam logic [5:0]      SH_SECOND  = 6'd46;

  typedef struct packed {
    logic signed [15:0] sy;
    logic [4:0]         sday;
    logic [4:0]         shour;
    logic [5:0]         smin;
    logic signed [20:0] mtot;
    logic signed [34:0] utot;
    logic signed [20:0] dday;
    logic signed [23:0] dhour;
    logic signed [23:0] dmin;
    logic               neg;
  } item_t;

  typedef struct packed {
    logic               ovf;
    logic [19:0]        micro;
    logic [5:0]         second;
    logic [5:0]         minute;
    logic [4:0]         hour;
    logic [4:0]         day;
    logic [3:0]         month;
    logic signed [15:0] year;
  } res_t;

  // Leap test from the year taken modulo 400.
  function automatic logic is_leap(input logic [8:0] r);
    is_leap = (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  // Month zero is December of the prior year and so has 31 days.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
      len = 5'd30;
    end
    month_len = len;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/dta_front.sv
// Front end: takes input beats, forms the month and microsecond sums, and queues items.
// Depends on dta_pkg; feeds dta_back through a two-entry queue.
`default_nettype none
module dta_front import dta_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // start_year, start_month, start_day, start_hour, start_minute, start_micro_in_minute,
  // dur_total_months, dur_days, dur_hours, dur_minutes, dur_micro, dur_negative, zero pad
  input  wire logic [191:0] s_axis_tdata,
  output logic              q_valid,
  input  wire logic         q_ready,
  output item_t             q_item
);

  item_t       mem [2];
  item_t       in_item;
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  always_comb begin
    in_item.sy    = $signed(s_axis_tdata[15:0]);
    in_item.sday  = s_axis_tdata[24:20];
    in_item.shour = s_axis_tdata[29:25];
    in_item.smin  = s_axis_tdata[35:30];
    in_item.mtot  = 21'($signed({1'b0, s_axis_tdata[19:16]}))
                  + 21'($signed(s_axis_tdata[81:62])) - 21'sd1;
    in_item.utot  = 35'($signed({1'b0, s_axis_tdata[61:36]}))
                  + 35'($signed(s_axis_tdata[183:151]));
    in_item.dday  = $signed(s_axis_tdata[102:82]);
    in_item.dhour = $signed(s_axis_tdata[126:103]);
    in_item.dmin  = $signed(s_axis_tdata[150:127]);
    in_item.neg   = s_axis_tdata[184];
  end

  assign s_axis_tready = (count != 2'd2);
  assign q_valid       = (count != 2'd0);
  assign q_item        = mem[rptr];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/dta_back.sv
// Back end: floor divisions by reciprocal multiplication, then the calendar walk.
// Depends on dta_pkg; takes items from dta_front and holds one result for the output.
`default_nettype none
module dta_back import dta_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire item_t q_item,
  output logic       res_valid,
  input  wire logic  res_ready,
  output res_t       res
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_REM  = 7'b0001000,
    ST_FIX  = 7'b0010000,
    ST_W400 = 7'b0100000,
    ST_WALK = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    OP_MON   = 3'd0,
    OP_YMOD  = 3'd1,
    OP_MICRO = 3'd2,
    OP_MIN   = 3'd3,
    OP_HOUR  = 3'd4,
    OP_SEC   = 3'd5
  } op_t;

  state_t                 state;
  op_t                    op;
  item_t                  cur;
  logic [MAGW-1:0]        dmag;
  logic [QW-1:0]          quo;
  logic [DIVW-1:0]        rem;
  logic [DIVW-1:0]        divisor;
  logic                   dneg;
  logic [3:0]             months;
  logic signed [YW-1:0]   years;
  logic [8:0]             ymod;
  logic [DIVW-1:0]        urem;
  logic signed [9:0]      qmin;
  logic signed [19:0]     qh;
  logic [5:0]             minutes;
  logic [4:0]             hours;
  logic [5:0]             seconds;
  logic [19:0]            micro;
  logic signed [DAYW-1:0] days;

  logic signed [SW-1:0]   operand;
  logic [SW-1:0]          opmag;
  logic [DIVW-1:0]        op_div;
  logic [RCPW-1:0]        op_rcp;
  logic [5:0]             op_sh;
  logic [MULW-1:0]        mul_a;
  logic [PRODW-1:0]       prod;
  logic [PRODW-1:0]       q_full;
  logic [QW+DIVW-1:0]     qd;
  logic [MAGW-1:0]        rdiff;
  logic signed [QW:0]     qs;
  logic [DIVW-1:0]        rs;
  logic                   leap;
  logic [4:0]             ml;
  logic [4:0]             mlp;
  logic [4:0]             sday_c;
  logic signed [YW-1:0]   yfin;
  logic                   res_load;

  always_comb begin
    unique case (op)
      OP_MON:   operand = SW'(cur.mtot);
      OP_YMOD:  operand = SW'(years);
      OP_MICRO: operand = SW'(cur.utot);
      OP_MIN:   operand = SW'($signed({1'b0, cur.smin})) + SW'(cur.dmin) + SW'(qmin);
      OP_HOUR:  operand = SW'($signed({1'b0, cur.shour})) + SW'(cur.dhour) + SW'(qh);
      OP_SEC:   operand = SW'($signed({1'b0, urem}));
      default:  operand = '0;
    endcase
    unique case (op)
      OP_MON: begin
        op_div = MONTHS_PER_YEAR;
        op_rcp = RCP_MONTH;
        op_sh  = SH_MONTH;
      end
      OP_YMOD: begin
        op_div = YEARS_PER_CYCLE;
        op_rcp = RCP_YEAR;
        op_sh  = SH_YEAR;
      end
      OP_MICRO: begin
        op_div = MICRO_PER_MINUTE;
        op_rcp = RCP_MICRO;
        op_sh  = SH_MICRO;
      end
      OP_MIN: begin
        op_div = MINUTES_PER_HOUR;
        op_rcp = RCP_MINUTE;
        op_sh  = SH_MINUTE;
      end
      OP_HOUR: begin
        op_div = HOURS_PER_DAY;
        op_rcp = RCP_HOUR;
        op_sh  = SH_HOUR;
      end
      OP_SEC: begin
        op_div = MICRO_PER_SECOND;
        op_rcp = RCP_SECOND;
        op_sh  = SH_SECOND;
      end
      default: begin
        op_div = MONTHS_PER_YEAR;
        op_rcp = RCP_MONTH;
        op_sh  = SH_MONTH;
      end
    endcase
    opmag  = operand[SW-1] ? 36'(-operand) : 36'(operand);
    mul_a  = (op == OP_MICRO) ? dmag[MAGW-1:MAGW-MULW] : dmag[MULW-1:0];
    prod   = mul_a * op_rcp;
    q_full = prod >> op_sh;
    qd     = quo * divisor;
    rdiff  = dmag - qd[MAGW-1:0];
    if (dneg && rem != '0) begin
      qs = -$signed({1'b0, quo}) - $signed((QW+1)'(1));
      rs = divisor - rem;
    end else if (dneg) begin
      qs = -$signed({1'b0, quo});
      rs = rem;
    end else begin
      qs = $signed({1'b0, quo});
      rs = rem;
    end
    leap = is_leap(ymod);
    ml   = month_len(months, leap);
    mlp  = month_len(months - 4'd1, leap);
    if (cur.sday > ml) begin
      sday_c = ml;
    end else if (cur.sday == 5'd0) begin
      sday_c = 5'd1;
    end else begin
      sday_c = cur.sday;
    end
    yfin = years;
    if (cur.sy > 16'sd0 && cur.neg && years <= 0) begin
      yfin = years - 20'sd1;
    end else if (cur.sy < 16'sd0 && !cur.neg && years >= 0) begin
      yfin = years + 20'sd1;
    end
    res_load = (state == ST_WALK) && (days >= 24'sd1) && (days <= $signed({19'b0, ml}))
             && (!res_valid || res_ready);
  end

  assign q_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_MON;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && !res_load) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            op    <= OP_MON;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          dmag    <= opmag[MAGW-1:0];
          dneg    <= operand[SW-1];
          divisor <= op_div;
          state   <= ST_MUL;
        end
        ST_MUL: begin
          quo   <= q_full[QW-1:0];
          state <= ST_REM;
        end
        ST_REM: begin
          rem   <= rdiff[DIVW-1:0];
          state <= ST_FIX;
        end
        ST_FIX: begin
          state <= ST_LOAD;
          unique case (op)
            OP_MON: begin
              months <= rs[3:0] + 4'd1;
              years  <= YW'(cur.sy) + qs[YW-1:0];
              op     <= OP_YMOD;
            end
            OP_YMOD: begin
              ymod <= rs[8:0];
              op   <= OP_MICRO;
            end
            OP_MICRO: begin
              urem <= rs;
              qmin <= qs[9:0];
              op   <= OP_MIN;
            end
            OP_MIN: begin
              minutes <= rs[5:0];
              qh      <= qs[19:0];
              op      <= OP_HOUR;
            end
            OP_HOUR: begin
              hours <= rs[4:0];
              days  <= DAYW'(cur.dday) + DAYW'($signed({1'b0, sday_c})) + DAYW'(qs);
              op    <= OP_SEC;
            end
            OP_SEC: begin
              seconds <= quo[5:0];
              micro   <= rs[19:0];
              state   <= ST_W400;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_W400: begin
          if (days > DAYS_PER_CYCLE) begin
            days  <= days - DAYS_PER_CYCLE;
            years <= years + 20'sd400;
          end else if (days <= -DAYS_PER_CYCLE) begin
            days  <= days + DAYS_PER_CYCLE;
            years <= years - 20'sd400;
          end else begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (days < 24'sd1) begin
            days <= days + $signed({19'b0, mlp});
            if (months == 4'd1) begin
              months <= 4'd12;
              years  <= years - 20'sd1;
              ymod   <= (ymod == 9'd0) ? 9'd399 : ymod - 9'd1;
            end else begin
              months <= months - 4'd1;
            end
          end else if (days > $signed({19'b0, ml})) begin
            days <= days - $signed({19'b0, ml});
            if (months == 4'd12) begin
              months <= 4'd1;
              years  <= years + 20'sd1;
              ymod   <= (ymod == 9'd399) ? 9'd0 : ymod + 9'd1;
            end else begin
              months <= months + 4'd1;
            end
          end else if (res_load) begin
            res.year   <= yfin[15:0];
            res.month  <= months;
            res.day    <= days[4:0];
            res.hour   <= hours;
            res.minute <= minutes;
            res.second <= seconds;
            res.micro  <= micro;
            res.ovf    <= (yfin < -20'sd32767) || (yfin > 20'sd32767);
            res_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/datetime_add_duration.sv
// Top level of the date-time plus duration block: stream ports, packing, front and back.
// Depends on dta_pkg, dta_front and dta_back.
//
// In the back end each beat is taken from the queue and goes through six floor divisions
// by a constant, each in four steps (load, reciprocal multiply, remainder, sign fix-up).
// The 400-year stage then removes one 400-year block at a time from the day count, and
// the month walk crosses one month at a time until the day count is in range. Last the
// result is handed over. A two-entry queue and a result register let new beats come in
// while the back end is busy or a result waits to be taken.
`default_nettype none
module datetime_add_duration import dta_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // start_year, start_month, start_day, start_hour, start_minute, start_micro_in_minute,
  // dur_total_months, dur_days, dur_hours, dur_minutes, dur_micro, dur_negative, zero pad
  input  wire logic [191:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_year, out_month, out_day, out_hour, out_minute, out_second, out_microsecond,
  // year_overflow, zero pad
  output logic [63:0]       m_axis_tdata
);

  item_t q_item;
  logic  q_valid;
  logic  q_ready;
  res_t  res;

  dta_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item)
  );

  dta_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {1'b0, res.ovf, res.micro, res.second, res.minute, res.hour,
                         res.day, res.month, res.year};

endmodule
`default_nettype wire

### dv/tb.sv
// Self-checking bench for datetime_add_duration: directed rows, then random date-time shifts.
// Results are predicted in the bench and checked per field; needs only dta_pkg and the RTL.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] year;
    logic [3:0]         mon;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [25:0]        micro;
    logic signed [19:0] dmon;
    logic signed [20:0] dday;
    logic signed [23:0] dhour;
    logic signed [23:0] dmin;
    logic signed [32:0] dmicro;
    logic               neg;
  } shift_t;

  typedef struct {
    logic signed [15:0] year;
    logic [3:0]         mon;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [19:0]        usec;
    logic               ovf;
  } stamp_t;

  typedef struct {
    shift_t arg;
    bit     fixed;
    stamp_t want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // start_year, start_month, start_day, start_hour, start_minute, start_micro_in_minute,
  // dur_total_months, dur_days, dur_hours, dur_minutes, dur_micro, dur_negative, zero pad
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // out_year, out_month, out_day, out_hour, out_minute, out_second, out_microsecond,
  // year_overflow, zero pad
  logic [63:0]  m_axis_tdata;

  stamp_t pending_stamps[$];
  int     failures = 0;
  int     send_idle_pct = 19;
  int     recv_idle_pct = 48;
  int     recv_hold = 0;

  datetime_add_duration u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint floor_mod(longint a, longint b);
    return a - floor_div(a, b) * b;
  endfunction

  function automatic longint days_in(longint y, longint m);
    bit leap;
    if (m < 1) begin
      y = y - 1;
      m = 12;
    end
    leap = floor_mod(y, 400) == 0 || (floor_mod(y, 100) != 0 && floor_mod(y, 4) == 0);
    if (m == 2) return leap ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic stamp_t shifted_stamp(shift_t x);
    stamp_t r;
    longint sy, mtot, mo, yr, utot, urem, mins, hrs, carry, last, sd, days, step;
    sy = x.year;
    mtot = longint'(x.mon) + x.dmon - 1;
    mo = floor_mod(mtot, 12) + 1;
    yr = sy + floor_div(mtot, 12);
    utot = longint'(x.micro) + x.dmicro;
    urem = floor_mod(utot, 60000000);
    mins = longint'(x.minute) + x.dmin + floor_div(utot, 60000000);
    hrs = longint'(x.hour) + x.dhour + floor_div(mins, 60);
    mins = floor_mod(mins, 60);
    carry = floor_div(hrs, 24);
    hrs = floor_mod(hrs, 24);
    last = days_in(yr, mo);
    sd = x.day;
    if (sd > last) sd = last;
    if (sd < 1) sd = 1;
    days = x.dday + sd + carry;
    while (days > 146097) begin
      days -= 146097;
      yr += 400;
    end
    while (days <= -146097) begin
      days += 146097;
      yr -= 400;
    end
    forever begin
      if (days < 1) begin
        days += days_in(yr, mo - 1);
        step = -1;
      end else if (days > days_in(yr, mo)) begin
        days -= days_in(yr, mo);
        step = 1;
      end else begin
        break;
      end
      yr += floor_div(mo + step - 1, 12);
      mo = floor_mod(mo + step - 1, 12) + 1;
    end
    if (sy > 0 && x.neg && yr <= 0) yr--;
    if (sy < 0 && !x.neg && yr >= 0) yr++;
    r.year = yr[15:0];
    r.mon = mo[3:0];
    r.day = days[4:0];
    r.hour = hrs[4:0];
    r.minute = mins[5:0];
    r.second = 6'(urem / 1000000);
    r.usec = 20'(urem % 1000000);
    r.ovf = yr < -32767 || yr > 32767;
    return r;
  endfunction

  function automatic shift_t mk(longint y, longint mo, longint d, longint h, longint mi,
                                longint us, longint dm, longint dd, longint dh,
                                longint dmn, longint du, bit n);
    shift_t x;
    x.year = y[15:0]; x.mon = mo[3:0]; x.day = d[4:0]; x.hour = h[4:0];
    x.minute = mi[5:0]; x.micro = us[25:0]; x.dmon = dm[19:0]; x.dday = dd[20:0];
    x.dhour = dh[23:0]; x.dmin = dmn[23:0]; x.dmicro = du[32:0]; x.neg = n;
    return x;
  endfunction

  function automatic stamp_t st(longint y, longint mo, longint d, longint h, longint mi,
                                longint s, longint us, bit o);
    stamp_t r;
    r.year = y[15:0]; r.mon = mo[3:0]; r.day = d[4:0]; r.hour = h[4:0];
    r.minute = mi[5:0]; r.second = s[5:0]; r.usec = us[19:0]; r.ovf = o;
    return r;
  endfunction

  function automatic longint signed_pick(int full_w, int near, bit negative);
    longint v;
    if ($urandom_range(19) == 0) begin
      v = {$urandom, $urandom};
      v = v & ((longint'(1) << full_w) - 1);
      if (v[full_w-1]) v = v - (longint'(1) << full_w);
      return v;
    end
    v = $urandom_range(near);
    return negative ? -v : v;
  endfunction

  function automatic shift_t random_shift();
    shift_t x;
    bit negative, wild;
    longint y;
    negative = $urandom_range(1);
    wild = $urandom_range(9) == 0;
    case ($urandom_range(9))
      0: y = $signed(16'($urandom));
      1: y = 0;
      2, 3: y = -longint'($urandom_range(3000, 1));
      default: y = $urandom_range(3000, 1);
    endcase
    x.year = y[15:0];
    x.mon = wild ? 4'($urandom) : 4'($urandom_range(12, 1));
    x.day = wild ? 5'($urandom) : 5'($urandom_range(31, 1));
    x.hour = wild ? 5'($urandom) : 5'($urandom_range(23));
    x.minute = wild ? 6'($urandom) : 6'($urandom_range(59));
    x.micro = wild ? 26'($urandom) : 26'($urandom_range(59999999));
    x.dmon = 20'(signed_pick(20, 30, negative));
    x.dday = 21'(signed_pick(21, 400, negative));
    x.dhour = 24'(signed_pick(24, 100, negative));
    x.dmin = 24'(signed_pick(24, 3000, negative));
    x.dmicro = 33'(signed_pick(33, 200000000, negative));
    x.neg = $urandom_range(15) == 0 ? 1'($urandom) : negative;
    return x;
  endfunction

  task automatic send_beat(shift_t x, bit fixed, stamp_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, x.neg, x.dmicro, x.dmin, x.dhour, x.dday, x.dmon, x.micro,
                     x.minute, x.hour, x.day, x.mon, x.year};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_stamps.push_back(fixed ? want : shifted_stamp(x));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    stamp_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = st($signed(m_axis_tdata[15:0]), m_axis_tdata[19:16], m_axis_tdata[24:20],
               m_axis_tdata[29:25], m_axis_tdata[35:30], m_axis_tdata[41:36],
               m_axis_tdata[61:42], m_axis_tdata[62]);
      if (pending_stamps.size() == 0) begin
        $error("result beat with nothing expected");
        failures++;
      end else begin
        want = pending_stamps.pop_front();
        if (got.year !== want.year) begin
          $error("out_year expected %0d got %0d", want.year, got.year); failures++;
        end
        if (got.mon !== want.mon) begin
          $error("out_month expected %0d got %0d", want.mon, got.mon); failures++;
        end
        if (got.day !== want.day) begin
          $error("out_day expected %0d got %0d", want.day, got.day); failures++;
        end
        if (got.hour !== want.hour) begin
          $error("out_hour expected %0d got %0d", want.hour, got.hour); failures++;
        end
        if (got.minute !== want.minute) begin
          $error("out_minute expected %0d got %0d", want.minute, got.minute); failures++;
        end
        if (got.second !== want.second) begin
          $error("out_second expected %0d got %0d", want.second, got.second); failures++;
        end
        if (got.usec !== want.usec) begin
          $error("out_microsecond expected %0d got %0d", want.usec, got.usec); failures++;
        end
        if (got.ovf !== want.ovf) begin
          $error("year_overflow expected %0d got %0d", want.ovf, got.ovf); failures++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    stamp_t none;
    none = st(0, 0, 0, 0, 0, 0, 0, 0);
    rows.push_back('{mk(2000, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     st(2000, 1, 1, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(2000, 2, 28, 0, 0, 0, 0, 1, 0, 0, 0, 0), 1,
                     st(2000, 2, 29, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(1900, 2, 28, 0, 0, 0, 0, 1, 0, 0, 0, 0), 1,
                     st(1900, 3, 1, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(2001, 1, 31, 0, 0, 0, 1, 0, 0, 0, 0, 0), 1,
                     st(2001, 2, 28, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(1, 1, 1, 0, 0, 0, -12, 0, 0, 0, 0, 1), 1,
                     st(-1, 1, 1, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(-1, 1, 1, 0, 0, 0, 12, 0, 0, 0, 0, 0), 1,
                     st(1, 1, 1, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(32767, 12, 31, 23, 59, 59999999, 0, 0, 0, 0, 1, 0), 1,
                     st(-32768, 1, 1, 0, 0, 0, 0, 1)});
    rows.push_back('{mk(-32767, 1, 1, 0, 0, 0, -1, 0, 0, 0, 0, 1), 1,
                     st(-32768, 12, 1, 0, 0, 0, 0, 1)});
    rows.push_back('{mk(2001, 1, 1, 0, 0, 0, 0, -1, 0, 0, 0, 1), 1,
                     st(2000, 12, 31, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(2001, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     st(2001, 3, 1, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(1999, 12, 31, 23, 59, 59999999, 0, 0, 0, 0, 4294967295, 0), 0, none});
    rows.push_back('{mk(-5, 1, 1, 0, 0, 0, 0, 0, 0, 0, -4294967296, 1), 0, none});
    rows.push_back('{mk(1234, 15, 31, 31, 63, 67108863, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(1234, 0, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(0, 6, 15, 12, 30, 0, -7, 3, 0, 0, 0, 1), 0, none});
    rows.push_back('{mk(100, 2, 29, 1, 2, 3, 524287, 1048575, 8388607, 8388607,
                        4294967295, 0), 0, none});
    rows.push_back('{mk(-100, 11, 30, 22, 1, 4, -524288, -1048576, -8388608, -8388608,
                        -4294967296, 1), 0, none});
    rows.push_back('{mk(-32768, 7, 4, 5, 6, 7, 100, 40, 5, 5, 5, 1), 0, none});
    rows.push_back('{mk(400, 3, 1, 0, 0, 0, 0, 146097, 0, 0, 0, 1), 0, none});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_beat(rows[i].arg, rows[i].fixed, rows[i].want);
    for (int i = 0; i < 360; i++) send_beat(random_shift(), 0, none);
    drain();

    send_idle_pct = 48;
    recv_idle_pct = 19;
    recv_hold = 3000;
    for (int i = 0; i < 385; i++) send_beat(random_shift(), 0, none);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 385; i++) send_beat(random_shift(), 0, none);
    drain();
    repeat (400) @(posedge clk);

    if (failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #500ms;
    $display("tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
hw/rtl/dta_pkg.sv
hw/rtl/dta_front.sv
hw/rtl/dta_back.sv
hw/rtl/datetime_add_duration.sv
dv/tb.sv
